// ----- sv/cbt_pkg.sv -----
package cbt_pkg;

    localparam int OUT_W  = 14;
    localparam int STEP_W = 6;
    localparam int TAB_N  = 2 ** STEP_W;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_C1_IDX = 1'b0;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_ERASE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_RECIP,
        ST_DIV,
        ST_FIX,
        ST_LOAD
    } t_state;

    // bernstein weight k at step j, scaled by s^3
    function automatic longint bz_weight(input int k, input int j, input int s);
        longint u;
        longint jj;
        longint w;
        u  = longint'(s - j);
        jj = longint'(j);
        w  = 0;
        if (j <= s) begin
            case (k)
                0:       w = u * u * u;
                1:       w = 3 * u * u * jj;
                2:       w = 3 * u * jj * jj;
                default: w = jj * jj * jj;
            endcase
        end
        return w;
    endfunction

endpackage

// ----- sv/cbt_in_if.sv -----
interface cbt_in_if #(
    parameter int COORD_BITS = 12
) ();
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;

    modport source (output valid, output mode, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input mode, input pos_x, input pos_y, output ready);
endinterface

// ----- sv/cbt_out_if.sv -----
interface cbt_out_if import cbt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] curve_x;
    logic signed [OUT_W-1:0] curve_y;
    logic [STEP_W-1:0]       step_index;
    logic                    last;

    modport source (output valid, output curve_x, output curve_y, output step_index,
                    output last, input ready);
    modport sink   (input valid, input curve_x, input curve_y, input step_index,
                    input last, output ready);
endinterface

// ----- sv/cubic_bezier_tessellator.sv -----
// cubic bezier tessellator
// i_in carries one word per control point (mode, pos_x, pos_y); mode erase
// drops all stored points. every third point after the first closes a cubic
// segment and o_out then delivers SEGMENTS+1 words (curve_x, curve_y,
// step_index, last), with last set on the final word of the segment.
// c1_enable sits at apb byte address 0; pready is always high.
// a point that closes no segment, an erase and a point past capacity leave
// the block idle, so i_in stays ready.
// for a closing point, each curve point goes through the mac, reciprocal,
// divide and fix steps for x, then for y, and then the load step. each coordinate
// runs six passes through the one shared multiplier (four weight products,
// a reciprocal product and a back-multiply for the rounding correction).
// the output register holds a finished word while o_out stalls; the next
// point is computed meanwhile and waits in the load step, and i_in stays
// low until the final word of the segment has been loaded into the output register.
// reset clears the point count, c1_enable and the output valid.
module cubic_bezier_tessellator import cbt_pkg::*; #(
    parameter int MAX_POINTS = 1024,
    parameter int SEGMENTS   = 32,
    parameter int COORD_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cbt_in_if.sink            i_in,
    cbt_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam longint CUBE  = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;
    localparam int     WW    = $clog2(CUBE + 1);
    localparam longint DIVC  = 2 * CUBE;
    localparam int     DW    = $clog2(DIVC + 1);
    localparam int     NW    = COORD_BITS + 3 + WW;
    localparam longint RECIP = (longint'(1) << NW) / DIVC;
    localparam int     MW    = $clog2(RECIP + 1);
    localparam int     QW    = COORD_BITS + 2;
    localparam int     PW    = COORD_BITS + 2;
    localparam int     NUM_W = PW + WW + 2;
    localparam int     TW    = NUM_W + 2;
    localparam longint OFS   = CUBE + (longint'(1) << COORD_BITS) * DIVC;
    localparam int     AW    = NW + 1;
    localparam int     BW0   = (WW > MW) ? WW : MW;
    localparam int     BW    = ((BW0 > DW) ? BW0 : DW) + 1;
    localparam int     PRW   = AW + BW;
    localparam int     RW    = (QW + 1 > OUT_W) ? QW + 1 : OUT_W;
    localparam int     CNT_W = $clog2(MAX_POINTS + 1);

    localparam logic [2:0]  K_LAST  = 3'd4;
    localparam logic        COORD_X = 1'b0;
    localparam logic        COORD_Y = 1'b1;
    localparam logic [NW:0] REM_LIM = (NW + 1)'(2 * DIVC);

    t_state r_state, n_state;

    logic [CNT_W-1:0]      r_count, n_count;
    logic [1:0]            r_phase, n_phase;
    logic                  r_c1, n_c1;
    logic                  r_ovalid, n_ovalid;

    logic [COORD_BITS-1:0] r_hx [4];
    logic [COORD_BITS-1:0] n_hx [4];
    logic [COORD_BITS-1:0] r_hy [4];
    logic [COORD_BITS-1:0] n_hy [4];
    logic signed [PW-1:0]  r_ctl_x [4];
    logic signed [PW-1:0]  n_ctl_x [4];
    logic signed [PW-1:0]  r_ctl_y [4];
    logic signed [PW-1:0]  n_ctl_y [4];

    logic [STEP_W-1:0]       r_j, n_j;
    logic [2:0]              r_k, n_k;
    logic                    r_coord, n_coord;
    logic signed [NUM_W-1:0] r_acc, n_acc;
    logic [NW-1:0]           r_n, n_n;
    logic [QW-1:0]           r_q, n_q;
    logic signed [PRW-1:0]   r_prod;
    logic [OUT_W-1:0]        r_res_x, n_res_x;
    logic [OUT_W-1:0]        r_res_y, n_res_y;
    logic [OUT_W-1:0]        r_ocx, n_ocx;
    logic [OUT_W-1:0]        r_ocy, n_ocy;
    logic [STEP_W-1:0]       r_ostep, n_ostep;
    logic                    r_olast, n_olast;

    logic [WW-1:0]           w_tab [4][TAB_N];
    logic signed [AW-1:0]    w_mul_a;
    logic signed [BW-1:0]    w_mul_b;
    logic signed [PRW-1:0]   w_prod;
    logic signed [NUM_W-1:0] w_sum;
    logic signed [TW-1:0]    w_tmp;
    logic [NW-1:0]           w_rem;
    logic                    w_ge;
    logic [QW:0]             w_q;
    logic [RW-1:0]           w_res;
    logic                    w_accept;
    logic                    w_close;
    logic                    w_load;
    logic                    w_cfg_wr;

    // weight tables, fixed at elaboration
    for (genvar gk = 0; gk < 4; gk++) begin : g_wk
        for (genvar gj = 0; gj < TAB_N; gj++) begin : g_wj
            assign w_tab[gk][gj] = WW'(bz_weight(gk, gj, SEGMENTS));
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_close    = (r_count >= CNT_W'(3)) && (r_phase == 2'd0);
    assign w_load     = (r_state == ST_LOAD) && (!r_ovalid || o_out.ready);
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1] == REG_C1_IDX) ? APB_DW'(r_c1) : '0;

    assign o_out.valid      = r_ovalid;
    assign o_out.curve_x    = r_ocx;
    assign o_out.curve_y    = r_ocy;
    assign o_out.step_index = r_ostep;
    assign o_out.last       = r_olast;

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ST_MAC: begin
                if (r_k != K_LAST) begin
                    w_mul_a = AW'((r_coord == COORD_X) ? r_ctl_x[r_k[1:0]]
                                                       : r_ctl_y[r_k[1:0]]);
                    w_mul_b = BW'(w_tab[r_k[1:0]][r_j]);
                end
            end
            ST_RECIP: begin
                w_mul_a = AW'(r_n);
                w_mul_b = BW'(RECIP);
            end
            ST_DIV: begin
                w_mul_a = AW'(r_prod[NW +: QW]);
                w_mul_b = BW'(DIVC);
            end
            default: ;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // rounding: offset keeps the dividend positive, quotient off by at most one
    assign w_sum = r_acc + $signed(r_prod[NUM_W-1:0]);
    assign w_tmp = (TW'(w_sum) <<< 1) + TW'(OFS);
    assign w_rem = r_n - r_prod[NW-1:0];
    assign w_ge  = (w_rem >= NW'(DIVC));
    assign w_q   = {1'b0, r_q} + (QW + 1)'(w_ge);
    assign w_res = RW'(w_q) - RW'(longint'(1) << COORD_BITS);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_phase  = r_phase;
        n_c1     = r_c1;
        n_hx     = r_hx;
        n_hy     = r_hy;
        n_ctl_x  = r_ctl_x;
        n_ctl_y  = r_ctl_y;
        n_j      = r_j;
        n_k      = r_k;
        n_coord  = r_coord;
        n_acc    = r_acc;
        n_n      = r_n;
        n_q      = r_q;
        n_res_x  = r_res_x;
        n_res_y  = r_res_y;
        n_ocx    = r_ocx;
        n_ocy    = r_ocy;
        n_ostep  = r_ostep;
        n_olast  = r_olast;
        n_ovalid = (r_ovalid && o_out.ready) ? 1'b0 : r_ovalid;

        if (w_cfg_wr && (paddr[APB_AW-1] == REG_C1_IDX)) begin
            n_c1 = pwdata[0];
        end

        if (w_load) begin
            n_ovalid = 1'b1;
            n_ocx    = r_res_x;
            n_ocy    = r_res_y;
            n_ostep  = r_j;
            n_olast  = (r_j == STEP_W'(SEGMENTS));
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.mode == MODE_ERASE) begin
                        n_count = '0;
                        n_phase = 2'd0;
                    end else if (r_count < CNT_W'(MAX_POINTS)) begin
                        if (w_close) begin
                            n_ctl_x[0] = $signed({2'b00, r_hx[1]});
                            n_ctl_y[0] = $signed({2'b00, r_hy[1]});
                            n_ctl_x[2] = $signed({2'b00, r_hx[3]});
                            n_ctl_y[2] = $signed({2'b00, r_hy[3]});
                            n_ctl_x[3] = $signed({2'b00, i_in.pos_x});
                            n_ctl_y[3] = $signed({2'b00, i_in.pos_y});
                            if (r_c1 && (r_count >= CNT_W'(6))) begin
                                n_ctl_x[1] = $signed({1'b0, r_hx[1], 1'b0})
                                           - $signed({2'b00, r_hx[0]});
                                n_ctl_y[1] = $signed({1'b0, r_hy[1], 1'b0})
                                           - $signed({2'b00, r_hy[0]});
                            end else begin
                                n_ctl_x[1] = $signed({2'b00, r_hx[2]});
                                n_ctl_y[1] = $signed({2'b00, r_hy[2]});
                            end
                            n_j     = '0;
                            n_k     = '0;
                            n_coord = COORD_X;
                            n_state = ST_MAC;
                        end
                        n_hx[0] = r_hx[1];
                        n_hx[1] = r_hx[2];
                        n_hx[2] = r_hx[3];
                        n_hx[3] = i_in.pos_x;
                        n_hy[0] = r_hy[1];
                        n_hy[1] = r_hy[2];
                        n_hy[2] = r_hy[3];
                        n_hy[3] = i_in.pos_y;
                        n_count = r_count + CNT_W'(1);
                        n_phase = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
                    end
                end
            end
            ST_MAC: begin
                n_acc = (r_k == 3'd0) ? '0 : w_sum;
                if (r_k == K_LAST) begin
                    n_n     = w_tmp[NW-1:0];
                    n_state = ST_RECIP;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            ST_RECIP: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_q     = r_prod[NW +: QW];
                n_state = ST_FIX;
            end
            ST_FIX: begin
                if (r_coord == COORD_X) begin
                    n_res_x = w_res[OUT_W-1:0];
                    n_coord = COORD_Y;
                    n_k     = '0;
                    n_state = ST_MAC;
                end else begin
                    n_res_y = w_res[OUT_W-1:0];
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (w_load) begin
                    if (r_j == STEP_W'(SEGMENTS)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j     = r_j + STEP_W'(1);
                        n_k     = '0;
                        n_coord = COORD_X;
                        n_state = ST_MAC;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_phase  <= 2'd0;
            r_c1     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_phase  <= n_phase;
            r_c1     <= n_c1;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hx    <= n_hx;
        r_hy    <= n_hy;
        r_ctl_x <= n_ctl_x;
        r_ctl_y <= n_ctl_y;
        r_j     <= n_j;
        r_k     <= n_k;
        r_coord <= n_coord;
        r_acc   <= n_acc;
        r_n     <= n_n;
        r_q     <= n_q;
        r_prod  <= w_prod;
        r_res_x <= n_res_x;
        r_res_y <= n_res_y;
        r_ocx   <= n_ocx;
        r_ocy   <= n_ocy;
        r_ostep <= n_ostep;
        r_olast <= n_olast;
    end

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIX) |-> ({1'b0, w_rem} < REM_LIM))
        else $error("rounding remainder out of range");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last == (o_out.step_index == STEP_W'(SEGMENTS))))
        else $error("last flag does not match step index");

    a_seg_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.mode == MODE_ADD) && (r_count < CNT_W'(MAX_POINTS)) && w_close)
        |=> ((r_state == ST_MAC) && (r_j == '0) && !i_in.ready))
        else $error("closing point did not start a segment");

endmodule
